FILE: rtl/gdr_pkg.sv
// Package for the Geiger dose-rate filter: configuration record, datapath
// commands and status, reset values and fixed constants. No dependencies.
`default_nettype none
package gdr_pkg;

  localparam int unsigned DivW     = 64;
  localparam int unsigned DivisorW = 27;
  localparam int unsigned RateW    = 40;

  localparam logic [26:0] DtScale  = 27'd100000000;
  localparam logic [16:0] OneQ16   = 17'd65536;
  localparam logic [31:0] BgRecip  = 32'h8888_8889;

  localparam logic [16:0] RstDeadTime  = 17'd0;
  localparam logic [15:0] RstBackgrnd  = 16'd0;
  localparam logic [23:0] RstSens      = 24'd0;
  localparam logic [15:0] RstRateThr   = 16'd200;
  localparam logic [15:0] RstJumpThr   = 16'd100;
  localparam logic [16:0] RstSlowAlpha = 17'd655;
  localparam logic [16:0] RstFastAlpha = 17'd22938;
  localparam logic [15:0] RstBoostLen  = 16'd20;

  typedef enum logic [2:0] {
    REG_DEAD_TIME  = 3'd0,
    REG_BACKGROUND = 3'd1,
    REG_SENSITIVITY = 3'd2,
    REG_RATE_THR   = 3'd3,
    REG_JUMP_THR   = 3'd4,
    REG_SLOW_ALPHA = 3'd5,
    REG_FAST_ALPHA = 3'd6,
    REG_BOOST_LEN  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [16:0] tube_dead_time;
    logic [15:0] bg_cpm;
    logic [23:0] sensitivity_x256;
    logic [15:0] rate_threshold;
    logic [15:0] jump_threshold;
    logic [16:0] slow_alpha;
    logic [16:0] fast_alpha;
    logic [15:0] boost_length;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIVC   = 4'd3,
    OP_CORR   = 4'd4,
    OP_EFF    = 4'd6,
    OP_EW1    = 4'd7,
    OP_EW2    = 4'd8,
    OP_EW3    = 4'd9,
    OP_EW4    = 4'd10,
    OP_DIVD   = 4'd11,
    OP_OUT    = 4'd12
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/gdr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gdr_pkg for widths.
`default_nettype none
module gdr_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [gdr_pkg::DivW-1:0]      dividend_i,
  input  wire logic [gdr_pkg::DivisorW-1:0]  divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [gdr_pkg::DivW-1:0]           quotient_o
);
  import gdr_pkg::*;

  logic [DivisorW-1:0] rem_q, div_q;
  logic [DivW-1:0]     quo_q;
  logic [5:0]          cnt_q;
  logic                busy_q, done_q;
  logic [DivisorW:0]   trial;
  logic                ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DivisorW'(trial - {1'b0, div_q}) : trial[DivisorW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: rtl/gdr_datapath.sv
// Datapath: dead-time correction, background, EWMA, dose and result registers.
// Depends on gdr_pkg and gdr_div.
`default_nettype none
module gdr_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire gdr_pkg::cfg_t    cfg_i,
  input  wire gdr_pkg::cmd_t    cmd_i,
  output gdr_pkg::status_t      status_o,
  input  wire logic [19:0]      raw_count_rate_i,
  input  wire logic             restart_i,
  output logic [31:0]           dose_rate_x256_o,
  output logic [39:0]           average_rate_q16_o,
  output logic [23:0]           latest_rate_o
);
  import gdr_pkg::*;

  logic [19:0] raw_q;
  logic        restart_q;
  logic [36:0] prod_q;
  logic [46:0] num_q;
  logic [39:0] corr_q, eff_q, avg_q, prev_q;
  logic [39:0] bg_q;
  logic [15:0] boost_q;
  logic        seeded_q;
  logic [16:0] alpha_q;
  logic [56:0] p1_q, p2_q;
  logic [31:0] dose_q;
  logic [39:0] avg_out_q;
  logic [23:0] latest_q;

  logic              div_start, div_busy, div_done;
  logic [DivW-1:0]   div_dividend, quo;
  logic [DivisorW-1:0] div_divisor;

  logic        use_corr;
  logic [39:0] diff;
  logic [61:0] bg_prod;
  logic [15:0] boost_eff;
  logic [16:0] fast_a, slow_a;
  logic [57:0] sum;
  logic [40:0] lat_sum;

  assign div_start = (cmd_i.op == OP_DIVC) || (cmd_i.op == OP_DIVD);

  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd_i.op)
      OP_DIVC: begin
        div_dividend = DivW'({num_q, 16'b0});
        div_divisor  = DivisorW'(DtScale - prod_q[26:0]);
      end
      OP_DIVD: begin
        div_dividend = DivW'({avg_q, 6'b0}) - DivW'({avg_q, 2'b0});
        div_divisor  = DivisorW'(cfg_i.sensitivity_x256);
      end
      default: ;
    endcase
  end

  gdr_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dividend), .divisor_i(div_divisor),
    .busy_o(div_busy), .done_o(div_done), .quotient_o(quo)
  );

  assign status_o.div_done = div_done;

  // background in Q16: bg * 65536 / 60 = (bg << 14) / 15 by reciprocal
  assign bg_prod   = 62'({cfg_i.bg_cpm, 14'b0}) * 62'(BgRecip);
  assign use_corr  = (cfg_i.tube_dead_time != '0) && (raw_q != '0)
                     && (prod_q < 37'(DtScale));
  assign diff      = (eff_q > prev_q) ? eff_q - prev_q : prev_q - eff_q;
  assign boost_eff = (diff > {8'b0, cfg_i.jump_threshold, 16'b0}) ? cfg_i.boost_length
                                                                  : boost_q;
  assign fast_a    = (cfg_i.fast_alpha > OneQ16) ? OneQ16 : cfg_i.fast_alpha;
  assign slow_a    = (cfg_i.slow_alpha > OneQ16) ? OneQ16 : cfg_i.slow_alpha;
  assign sum       = 58'(p1_q) + 58'(p2_q) + 58'd32768;
  assign lat_sum   = 41'(prev_q) + 41'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
      boost_q  <= '0;
      avg_q    <= '0;
      prev_q   <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: if (restart_i) begin
          seeded_q <= 1'b0;
          boost_q  <= '0;
          avg_q    <= '0;
          prev_q   <= '0;
        end
        OP_EW1: if (seeded_q) begin
          boost_q <= (boost_eff != '0) ? boost_eff - 16'd1 : boost_eff;
        end
        OP_EW4: begin
          avg_q    <= seeded_q ? sum[55:16] : eff_q;
          prev_q   <= eff_q;
          seeded_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        raw_q     <= raw_count_rate_i;
        restart_q <= restart_i;
      end
      OP_MUL: begin
        prod_q <= 37'(raw_q) * 37'(cfg_i.tube_dead_time);
        num_q  <= 47'(raw_q) * 47'(DtScale);
      end
      OP_CORR: begin
        corr_q <= !use_corr ? 40'({raw_q, 16'b0})
                  : (quo > DivW'(40'hFF_FFFF_FFFF)) ? 40'hFF_FFFF_FFFF : quo[39:0];
        bg_q   <= 40'(bg_prod[61:35]);
      end
      OP_EFF:  eff_q <= (corr_q > bg_q) ? corr_q - bg_q : '0;
      OP_EW1: alpha_q <= ((boost_eff != '0) || (eff_q > {8'b0, cfg_i.rate_threshold, 16'b0}))
                         ? fast_a : slow_a;
      OP_EW2: p1_q <= 57'(alpha_q) * 57'(eff_q);
      OP_EW3: p2_q <= 57'(OneQ16 - alpha_q) * 57'(avg_q);
      OP_OUT: begin
        if (restart_q) begin
          dose_q    <= '0;
          avg_out_q <= '0;
          latest_q  <= '0;
        end else begin
          dose_q    <= (cfg_i.sensitivity_x256 == '0) ? '0
                       : (quo > DivW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quo[31:0];
          avg_out_q <= avg_q;
          latest_q  <= (lat_sum[40:16] > 25'hFF_FFFF) ? 24'hFF_FFFF : lat_sum[39:16];
        end
      end
      default: ;
    endcase
  end

  assign dose_rate_x256_o   = dose_q;
  assign average_rate_q16_o = avg_out_q;
  assign latest_rate_o      = latest_q;

`ifndef NO_ASSERTIONS
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_LOAD && restart_i) |=> (!seeded_q && boost_q == '0))
    else $error("restart left filter state");
  a_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EW4) |=> seeded_q) else $error("average not seeded");
`endif

endmodule
`default_nettype wire

FILE: rtl/gdr_ctrl.sv
// Sequencer: input handshake, datapath command steps, output valid.
// Depends on gdr_pkg.
`default_nettype none
module gdr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               restart_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gdr_pkg::cmd_t           cmd_o,
  input  wire gdr_pkg::status_t   status_i
);
  import gdr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MUL   = 11'b00000000010,
    S_DIVC  = 11'b00000000100,
    S_WAITC = 11'b00000001000,
    S_CORR  = 11'b00000010000,
    S_EFF   = 11'b00000100000,
    S_EW1   = 11'b00001000000,
    S_EW2   = 11'b00010000000,
    S_EW3   = 11'b00100000000,
    S_EW4   = 11'b01000000000,
    S_DOSE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   waitd_q, waitd_d;
  logic   fin_q, fin_d;
  logic   can_out;

  assign can_out = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    waitd_d     = waitd_q;
    fin_d       = fin_q;
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (fin_q) begin
          if (can_out) begin
            cmd_o.op    = OP_OUT;
            out_valid_d = 1'b1;
            fin_d       = 1'b0;
          end
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.op = OP_LOAD;
            if (restart_i) fin_d = 1'b1;
            else state_d = S_MUL;
          end
        end
      end
      S_MUL:   begin cmd_o.op = OP_MUL;  state_d = S_DIVC; end
      S_DIVC:  begin cmd_o.op = OP_DIVC; state_d = S_WAITC; end
      S_WAITC: if (status_i.div_done) state_d = S_CORR;
      S_CORR:  begin cmd_o.op = OP_CORR; state_d = S_EFF; end
      S_EFF:   begin cmd_o.op = OP_EFF;  state_d = S_EW1; end
      S_EW1:   begin cmd_o.op = OP_EW1;  state_d = S_EW2; end
      S_EW2:   begin cmd_o.op = OP_EW2;  state_d = S_EW3; end
      S_EW3:   begin cmd_o.op = OP_EW3;  state_d = S_EW4; end
      S_EW4:   begin cmd_o.op = OP_EW4;  state_d = S_DOSE; end
      S_DOSE: begin
        if (!waitd_q) begin
          cmd_o.op = OP_DIVD;
          waitd_d  = 1'b1;
        end else if (status_i.div_done) begin
          waitd_d = 1'b0;
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      waitd_q     <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      waitd_q     <= waitd_d;
      fin_q       <= fin_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/geiger_dose_rate_filter.sv
// Top level of the Geiger dose-rate filter: APB register file, sequencer
// and datapath. Depends on gdr_pkg, gdr_ctrl and gdr_datapath.
//
// Usage: one count-per-second sample (raw_count_rate_i, restart_i) is
// transferred on the input valid/ready channel; exactly one result (dose,
// average, latest rate) is transferred on the output channel for each.
// One sample is processed at a time: in_ready_o is high only while the
// sequencer is idle. A normal sample runs through the sequencing steps and
// two passes of the shared restoring divider (dead-time correction, dose)
// before it raises output valid. A restart sample is marked pending at its
// transfer; its result of all zeros is written and output valid raised once
// the output register is free, and the next sample can be taken as output
// valid rises.
// The result sits in an output register; if the receiver stalls, the next
// sample is still taken and computed, then waits until the register frees.
// Reset clears the filter state and the output valid and loads the
// register defaults. Write configuration only while the block is idle.
`default_nettype none
module geiger_dose_rate_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [19:0] raw_count_rate_i,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      dose_rate_x256_o,
  output logic [39:0]      average_rate_q16_o,
  output logic [23:0]      latest_rate_o
);
  import gdr_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tube_dead_time    <= RstDeadTime;
      cfg_q.bg_cpm            <= RstBackgrnd;
      cfg_q.sensitivity_x256  <= RstSens;
      cfg_q.rate_threshold    <= RstRateThr;
      cfg_q.jump_threshold    <= RstJumpThr;
      cfg_q.slow_alpha        <= RstSlowAlpha;
      cfg_q.fast_alpha        <= RstFastAlpha;
      cfg_q.boost_length      <= RstBoostLen;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEAD_TIME:   cfg_q.tube_dead_time    <= pwdata[16:0];
        REG_BACKGROUND:  cfg_q.bg_cpm            <= pwdata[15:0];
        REG_SENSITIVITY: cfg_q.sensitivity_x256  <= pwdata[23:0];
        REG_RATE_THR:    cfg_q.rate_threshold    <= pwdata[15:0];
        REG_JUMP_THR:    cfg_q.jump_threshold    <= pwdata[15:0];
        REG_SLOW_ALPHA:  cfg_q.slow_alpha        <= pwdata[16:0];
        REG_FAST_ALPHA:  cfg_q.fast_alpha        <= pwdata[16:0];
        REG_BOOST_LEN:   cfg_q.boost_length      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEAD_TIME:   prdata = 32'(cfg_q.tube_dead_time);
      REG_BACKGROUND:  prdata = 32'(cfg_q.bg_cpm);
      REG_SENSITIVITY: prdata = 32'(cfg_q.sensitivity_x256);
      REG_RATE_THR:    prdata = 32'(cfg_q.rate_threshold);
      REG_JUMP_THR:    prdata = 32'(cfg_q.jump_threshold);
      REG_SLOW_ALPHA:  prdata = 32'(cfg_q.slow_alpha);
      REG_FAST_ALPHA:  prdata = 32'(cfg_q.fast_alpha);
      REG_BOOST_LEN:   prdata = 32'(cfg_q.boost_length);
      default:         prdata = '0;
    endcase
  end

  gdr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .restart_i,
    .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .status_i(status)
  );

  gdr_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_i(cfg_q), .cmd_i(cmd), .status_o(status),
    .raw_count_rate_i, .restart_i,
    .dose_rate_x256_o, .average_rate_q16_o, .latest_rate_o
  );

endmodule
`default_nettype wire
